>>> design/knap_pkg.sv
// Shared types and constants for the knapsack solver.
// No dependencies; used by knap_sweep and knapsack_solver_with_selection_unit.
`default_nettype none

package knap_pkg;

    localparam int CFG_W  = 10;
    localparam int WT_W   = 10;
    localparam int VAL_W  = 16;
    localparam int ROW_W  = 21;
    localparam int IDX_W  = 5;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;

    localparam logic [ROW_W-1:0] ROW_SAT = {ROW_W{1'b1}};

    localparam logic KIND_INDEX = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    typedef struct packed {
        logic             start;
        logic             first;
        logic [WT_W-1:0]  weight;
        logic [VAL_W-1:0] value;
    } sweep_cmd_t;

    typedef struct packed {
        logic done;
        logic take_we;
        logic take_bit;
    } sweep_stat_t;

endpackage

`default_nettype wire

>>> design/knap_sweep.sv
// Best-value row memory and the per-item read-modify-write sweep.
// Depends on knap_pkg.
`default_nettype none

module knap_sweep #(
    parameter int CW = 10
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire knap_pkg::sweep_cmd_t      cmd,
    input  wire logic [CW-1:0]             set_cap,
    input  wire logic                      best_rd,
    output knap_pkg::sweep_stat_t          stat,
    output logic [CW-1:0]                  take_cap,
    output logic [knap_pkg::ROW_W-1:0]     best_total
);

    localparam int XW = (CW > knap_pkg::WT_W) ? CW : knap_pkg::WT_W;
    localparam int RW = knap_pkg::ROW_W;

    logic [RW-1:0] row_mem [2**CW];

    logic                        run_reg;
    logic [CW-1:0]               c_reg;
    logic [knap_pkg::WT_W-1:0]   w_reg;
    logic [knap_pkg::VAL_W-1:0]  v_reg;
    logic                        first_reg;

    logic                        s1_vld_reg;
    logic [CW-1:0]               s1_c_reg;
    logic                        s1_fit_reg;
    logic                        s1_lozero_reg;
    logic [RW-1:0]               rd_a_reg;
    logic [RW-1:0]               rd_b_reg;

    logic [XW-1:0]  c_ext;
    logic [XW-1:0]  w_ext;
    logic           fit;
    logic [XW-1:0]  lo_ext;
    logic [CW-1:0]  addr_a;
    logic [CW-1:0]  addr_b;
    logic [RW-1:0]  old_val;
    logic [RW-1:0]  lo_val;
    logic [RW:0]    sum;
    logic [RW-1:0]  cand;
    logic           take;
    logic [RW-1:0]  new_val;

    always_comb begin
        c_ext  = XW'(c_reg);
        w_ext  = XW'(w_reg);
        fit    = (w_ext <= c_ext);
        lo_ext = c_ext - w_ext;
        addr_a = run_reg ? c_reg : set_cap;
        addr_b = fit ? lo_ext[CW-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        rd_a_reg <= row_mem[addr_a];
        rd_b_reg <= row_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= 1'b0;
            s1_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= run_reg;
            if (cmd.start) begin
                run_reg <= 1'b1;
            end else if (run_reg && c_reg == CW'(1)) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            c_reg     <= set_cap;
            w_reg     <= cmd.weight;
            v_reg     <= cmd.value;
            first_reg <= cmd.first;
        end else if (run_reg) begin
            c_reg <= c_reg - CW'(1);
        end
        s1_c_reg      <= c_reg;
        s1_fit_reg    <= fit;
        s1_lozero_reg <= (lo_ext == '0);
    end

    always_comb begin
        old_val = first_reg ? '0 : rd_a_reg;
        lo_val  = (first_reg || s1_lozero_reg) ? '0 : rd_b_reg;
        sum     = {1'b0, lo_val} + (RW+1)'(v_reg);
        cand    = sum[RW] ? knap_pkg::ROW_SAT : sum[RW-1:0];
        take    = s1_fit_reg && (cand > old_val);
        new_val = take ? cand : old_val;
    end

    always_ff @(posedge aclk) begin
        if (s1_vld_reg) begin
            row_mem[s1_c_reg] <= new_val;
        end
    end

    logic best_zero_reg;

    always_ff @(posedge aclk) begin
        best_zero_reg <= best_rd && (set_cap == '0);
    end

    always_comb begin
        stat.done     = s1_vld_reg && (s1_c_reg == CW'(1));
        stat.take_we  = s1_vld_reg;
        stat.take_bit = take;
        take_cap      = s1_c_reg;
        best_total    = best_zero_reg ? '0 : rd_a_reg;
    end

endmodule

`default_nettype wire

>>> design/knapsack_solver_with_selection_unit.sv
// Knapsack solver top level: item intake, take-bit memory, backtrack, result output.
// Depends on knap_pkg and knap_sweep.
// Item cost: the accept, then the row sweep from the set capacity down to entry 1,
// one row read-modify-write per cycle; the row memory port sets this rate.
// The last item adds a best-value read, the backtrack steps and a scan of the items on output.
// Reset (aresetn low, synchronous) empties the set; the first item of a set treats
// the row as zero and writes every entry later items read, so no clearing pass runs.
`default_nettype none

module knapsack_solver_with_selection_unit #(
    parameter int MAX_ITEMS    = 32,
    parameter int MAX_CAPACITY = 1023
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [knap_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // item_weight[9:0], item_value[25:10], zero fill
    input  wire logic [knap_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // selected_index[4:0], best_total[25:5], overflow[26], zero fill
    output logic [knap_pkg::M_DATA_W-1:0]          m_tdata,
    // result_kind
    output logic                                   m_tuser,
    output logic                                   m_tlast
);

    localparam int CW = $clog2(MAX_CAPACITY + 1);
    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam int WW = knap_pkg::WT_W;
    localparam int XW = (CW > WW) ? CW : WW;
    localparam int XC = (XW > knap_pkg::CFG_W) ? XW : knap_pkg::CFG_W;
    localparam int RW = knap_pkg::ROW_W;
    localparam logic [XC-1:0] CAP_MAX = XC'(MAX_CAPACITY);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_SWEEP   = 8'b0000_0010,
        ST_BEST_RD = 8'b0000_0100,
        ST_BEST_LD = 8'b0000_1000,
        ST_BT_RD   = 8'b0001_0000,
        ST_BT_UP   = 8'b0010_0000,
        ST_EMIT    = 8'b0100_0000,
        ST_FINAL   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [knap_pkg::CFG_W-1:0] cap_cfg_reg;
    logic [CW-1:0]              set_cap_reg, set_cap_next;
    logic [NW-1:0]              count_reg, count_next;
    logic                       ovf_reg, ovf_next;
    logic                       last_reg, last_next;
    logic [NW-1:0]              i_reg, i_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic [NW-1:0]              j_reg, j_next;
    logic [MAX_ITEMS-1:0]       chosen_reg, chosen_next;
    logic [RW-1:0]              best_reg, best_next;

    logic                       out_vld_reg, out_vld_next;
    logic                       out_kind_reg, out_kind_next;
    logic [knap_pkg::IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [RW-1:0]              out_total_reg, out_total_next;
    logic                       out_ovf_reg, out_ovf_next;
    logic                       out_last_reg, out_last_next;

    logic [WW-1:0]              wt_mem [MAX_ITEMS];
    logic [WW-1:0]              wt_q_reg;
    logic                       tk_mem [MAX_ITEMS * (2**CW)];
    logic                       tk_q_reg;

    logic [WW-1:0]              in_weight;
    logic [knap_pkg::VAL_W-1:0] in_value;
    logic                       accept;
    logic [XC-1:0]              cfg_ext;
    logic [CW-1:0]              cap_sat;
    logic [CW-1:0]              cap_eff;
    logic                       room;
    logic                       out_free;
    logic [IW-1:0]              bt_item;
    logic [IW-1:0]              j_item;
    logic [IW-1:0]              wr_item;
    logic [XW-1:0]              rem_ext;
    logic [XW-1:0]              wq_ext;
    logic [XW-1:0]              rem_sub;

    knap_pkg::sweep_cmd_t       sw_cmd;
    knap_pkg::sweep_stat_t      sw_stat;
    logic [CW-1:0]              sw_take_cap;
    logic [RW-1:0]              sw_best;
    logic                       sw_best_rd;

    always_comb begin
        in_weight = s_tdata[WW-1:0];
        in_value  = s_tdata[WW +: knap_pkg::VAL_W];
        s_tready  = (state_reg == ST_IDLE);
        accept    = s_tvalid && s_tready;
        cfg_ext   = XC'(cap_cfg_reg);
        cap_sat   = (cfg_ext > CAP_MAX) ? CW'(CAP_MAX) : CW'(cfg_ext);
        cap_eff   = (count_reg == '0) ? cap_sat : set_cap_reg;
        room      = (count_reg < NW'(MAX_ITEMS));
        out_free  = !out_vld_reg || m_tready;
        bt_item   = IW'(i_reg - NW'(1));
        j_item    = IW'(j_reg);
        wr_item   = IW'(count_reg);
        rem_ext   = XW'(rem_reg);
        wq_ext    = XW'(wt_q_reg);
        rem_sub   = rem_ext - wq_ext;
    end

    knap_sweep #(
        .CW (CW)
    ) u_sweep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (sw_cmd),
        .set_cap    (cap_eff),
        .best_rd    (sw_best_rd),
        .stat       (sw_stat),
        .take_cap   (sw_take_cap),
        .best_total (sw_best)
    );

    always_ff @(posedge aclk) begin
        if (accept && room) begin
            wt_mem[wr_item] <= in_weight;
        end
        if (sw_stat.take_we) begin
            tk_mem[{wr_item, sw_take_cap}] <= sw_stat.take_bit;
        end
        wt_q_reg <= wt_mem[bt_item];
        tk_q_reg <= tk_mem[{bt_item, rem_reg}];
    end

    always_comb begin
        state_next     = state_reg;
        set_cap_next   = set_cap_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        i_next         = i_reg;
        rem_next       = rem_reg;
        j_next         = j_reg;
        chosen_next    = chosen_reg;
        best_next      = best_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_total_next = out_total_reg;
        out_ovf_next   = out_ovf_reg;
        out_last_next  = out_last_reg;
        sw_cmd.start   = 1'b0;
        sw_cmd.first   = (count_reg == '0);
        sw_cmd.weight  = in_weight;
        sw_cmd.value   = in_value;
        sw_best_rd     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    set_cap_next = cap_eff;
                    last_next    = s_tlast;
                    if (!room) begin
                        ovf_next   = 1'b1;
                        state_next = s_tlast ? ST_BEST_RD : ST_IDLE;
                    end else if (cap_eff != '0) begin
                        sw_cmd.start = 1'b1;
                        state_next   = ST_SWEEP;
                    end else begin
                        count_next = count_reg + NW'(1);
                        state_next = s_tlast ? ST_BEST_RD : ST_IDLE;
                    end
                end
            end
            ST_SWEEP: begin
                if (sw_stat.done) begin
                    count_next = count_reg + NW'(1);
                    state_next = last_reg ? ST_BEST_RD : ST_IDLE;
                end
            end
            ST_BEST_RD: begin
                sw_best_rd = 1'b1;
                state_next = ST_BEST_LD;
            end
            ST_BEST_LD: begin
                best_next  = sw_best;
                i_next     = count_reg;
                rem_next   = set_cap_reg;
                state_next = ST_BT_RD;
            end
            ST_BT_RD: begin
                if (i_reg == '0 || rem_reg == '0) begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_BT_UP;
                end
            end
            ST_BT_UP: begin
                if (tk_q_reg) begin
                    chosen_next[bt_item] = 1'b1;
                    rem_next = (wq_ext <= rem_ext) ? CW'(rem_sub) : '0;
                end
                i_next     = i_reg - NW'(1);
                state_next = ST_BT_RD;
            end
            ST_EMIT: begin
                if (j_reg == count_reg) begin
                    state_next = ST_FINAL;
                end else if (!chosen_reg[j_item]) begin
                    j_next = j_reg + NW'(1);
                end else if (out_free) begin
                    out_vld_next   = 1'b1;
                    out_kind_next  = knap_pkg::KIND_INDEX;
                    out_idx_next   = knap_pkg::IDX_W'(j_reg);
                    out_total_next = '0;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = 1'b0;
                    j_next         = j_reg + NW'(1);
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_vld_next   = 1'b1;
                    out_kind_next  = knap_pkg::KIND_TOTAL;
                    out_idx_next   = '0;
                    out_total_next = best_reg;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = 1'b1;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    chosen_next    = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cap_cfg_reg <= knap_pkg::CFG_W'(1023);
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            chosen_reg  <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_we) begin
                cap_cfg_reg <= cfg_wdata;
            end
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            chosen_reg  <= chosen_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        set_cap_reg   <= set_cap_next;
        last_reg      <= last_next;
        i_reg         <= i_next;
        rem_reg       <= rem_next;
        j_reg         <= j_next;
        best_reg      <= best_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    always_comb begin
        m_tvalid = out_vld_reg;
        m_tuser  = out_kind_reg;
        m_tlast  = out_last_reg;
        m_tdata  = '0;
        m_tdata[knap_pkg::IDX_W-1:0]            = out_idx_reg;
        m_tdata[knap_pkg::IDX_W +: RW]          = out_total_reg;
        m_tdata[knap_pkg::IDX_W + RW]           = out_ovf_reg;
    end

endmodule

`default_nettype wire

>>> verif/knapsack_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the knapsack solver: follows capacity writes and accepted items,
// works out each set's chosen indices and best total, and compares every result item.
// Depends on knap_pkg; instantiated by tb_top beside the solver.
module knapsack_result_checker #(
    parameter int MAX_ITEMS    = 32,
    parameter int MAX_CAPACITY = 1023
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [knap_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [knap_pkg::S_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [knap_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire logic                           m_tuser,
    input  wire logic                           m_tlast,
    output int                                  mismatches,
    output int                                  results_due
);

    typedef struct packed {
        logic                       kind;
        logic [knap_pkg::IDX_W-1:0] index;
        logic [knap_pkg::ROW_W-1:0] total;
        logic                       ovf;
        logic                       fin;
    } outcome_t;

    logic [knap_pkg::CFG_W-1:0] capacity_reg = {knap_pkg::CFG_W{1'b1}};
    int                         set_cap      = 0;
    int                         items_held   = 0;
    logic                       dropped      = 1'b0;
    logic [knap_pkg::ROW_W-1:0] row_best [MAX_CAPACITY+1];
    bit                         take_map [MAX_ITEMS][MAX_CAPACITY+1];
    logic [knap_pkg::WT_W-1:0]  wt_held  [MAX_ITEMS];
    outcome_t                   outcomes_due [$];

    initial begin
        mismatches  = 0;
        results_due = 0;
    end

    function automatic void clear_set();
        for (int c = 0; c <= MAX_CAPACITY; c++) begin
            row_best[c] = '0;
            for (int i = 0; i < MAX_ITEMS; i++) begin
                take_map[i][c] = 1'b0;
            end
        end
        for (int i = 0; i < MAX_ITEMS; i++) begin
            wt_held[i] = '0;
        end
        items_held = 0;
        dropped    = 1'b0;
        set_cap    = 0;
    endfunction

    task automatic solve_item(input logic [knap_pkg::WT_W-1:0] w,
                              input logic [knap_pkg::VAL_W-1:0] v,
                              input logic fin);
        int                         c;
        int                         i;
        int                         rem;
        logic [knap_pkg::ROW_W:0]   cand;
        bit                         picked [MAX_ITEMS];
        outcome_t                   res;
        if (items_held == 0) begin
            set_cap = (capacity_reg > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity_reg);
        end
        if (items_held < MAX_ITEMS) begin
            wt_held[items_held] = w;
            for (c = set_cap; c >= 1; c--) begin
                take_map[items_held][c] = 1'b0;
                if (int'(w) <= c) begin
                    cand = {1'b0, row_best[c - int'(w)]} + v;
                    if (cand > knap_pkg::ROW_SAT) begin
                        cand = {1'b0, knap_pkg::ROW_SAT};
                    end
                    if (cand > {1'b0, row_best[c]}) begin
                        row_best[c] = cand[knap_pkg::ROW_W-1:0];
                        take_map[items_held][c] = 1'b1;
                    end
                end
            end
            row_best[0] = '0;
            items_held++;
        end else begin
            dropped = 1'b1;
        end
        if (!fin) begin
            return;
        end
        for (i = 0; i < MAX_ITEMS; i++) begin
            picked[i] = 1'b0;
        end
        rem = set_cap;
        for (i = items_held; i > 0 && rem > 0; i--) begin
            if (take_map[i-1][rem]) begin
                picked[i-1] = 1'b1;
                rem = (int'(wt_held[i-1]) <= rem) ? rem - int'(wt_held[i-1]) : 0;
            end
        end
        for (i = 0; i < items_held; i++) begin
            if (picked[i]) begin
                res.kind  = knap_pkg::KIND_INDEX;
                res.index = knap_pkg::IDX_W'(i);
                res.total = '0;
                res.ovf   = dropped;
                res.fin   = 1'b0;
                outcomes_due.push_back(res);
            end
        end
        res.kind  = knap_pkg::KIND_TOTAL;
        res.index = '0;
        res.total = row_best[set_cap];
        res.ovf   = dropped;
        res.fin   = 1'b1;
        outcomes_due.push_back(res);
        clear_set();
    endtask

    always @(posedge aclk) begin : watch
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            capacity_reg = {knap_pkg::CFG_W{1'b1}};
            clear_set();
            outcomes_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind  = m_tuser;
                got.index = m_tdata[knap_pkg::IDX_W-1:0];
                got.total = m_tdata[knap_pkg::IDX_W +: knap_pkg::ROW_W];
                got.ovf   = m_tdata[knap_pkg::IDX_W + knap_pkg::ROW_W];
                got.fin   = m_tlast;
                if (outcomes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none", $time);
                    $display("%0t:   actual kind %0d index %0d total %0d ovf %0d last %0d",
                             $time, got.kind, got.index, got.total, got.ovf, got.fin);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got.kind !== want.kind || got.index !== want.index ||
                        got.total !== want.total || got.ovf !== want.ovf ||
                        got.fin !== want.fin) begin
                        mismatches++;
                        $display("%0t: expected kind %0d index %0d total %0d ovf %0d last %0d",
                                 $time, want.kind, want.index, want.total, want.ovf,
                                 want.fin);
                        $display("%0t:   actual kind %0d index %0d total %0d ovf %0d last %0d",
                                 $time, got.kind, got.index, got.total, got.ovf, got.fin);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                solve_item(s_tdata[knap_pkg::WT_W-1:0],
                           s_tdata[knap_pkg::WT_W +: knap_pkg::VAL_W], s_tlast);
            end
            if (cfg_we) begin
                capacity_reg = cfg_wdata;
            end
        end
        results_due = outcomes_due.size();
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the knapsack solver: clock, reset, capacity writes and item stimulus
// with bursty input and a stalling result side; gives the verdict.
// Depends on knap_pkg, knapsack_solver_with_selection_unit and knapsack_result_checker.
module tb_top;

    localparam int MAX_ITEMS    = 32;
    localparam int MAX_CAPACITY = 1023;
    localparam int WT_TOP       = (1 << knap_pkg::WT_W) - 1;
    localparam int ITEM_TARGET  = 360;
    localparam int BIG_BUDGET   = 48;

    typedef enum {STALL_NONE, STALL_COIN, STALL_SPARSE, STALL_HOLD} stall_mode_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [knap_pkg::CFG_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic [knap_pkg::S_DATA_W-1:0]   s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tready  = 1'b0;
    wire                             s_tready;
    wire                             m_tvalid;
    wire  [knap_pkg::M_DATA_W-1:0]   m_tdata;
    wire                             m_tuser;
    wire                             m_tlast;
    int                              mismatches;
    int                              results_due;

    int                    items_sent = 0;
    int                    burst_left = 1;
    int                    big_items  = 0;
    int                    mode_left  = 0;
    stall_mode_t           stall_mode = STALL_NONE;

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    knapsack_solver_with_selection_unit #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    knapsack_result_checker #(
        .MAX_ITEMS    (MAX_ITEMS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    always @(negedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:   m_tready <= 1'b1;
            STALL_COIN:   m_tready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: m_tready <= ($urandom_range(0, 5) == 0);
            default:      m_tready <= 1'b0;
        endcase
    end

    task automatic send_item(input logic [knap_pkg::WT_W-1:0] w,
                             input logic [knap_pkg::VAL_W-1:0] v,
                             input logic fin);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(knap_pkg::S_DATA_W-knap_pkg::VAL_W-knap_pkg::WT_W){1'b0}}, v, w};
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 24)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (results_due == 0);
        repeat (100) @(negedge aclk);
    endtask

    task automatic load_capacity(input int cap);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= knap_pkg::CFG_W'(cap);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_set(input int n, input int cap);
        int                         k;
        int                         wmax;
        logic [knap_pkg::WT_W-1:0]  w;
        logic [knap_pkg::VAL_W-1:0] v;
        wmax = (cap + 2 > WT_TOP) ? WT_TOP : cap + 2;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) == 0) begin
                w = knap_pkg::WT_W'($urandom_range(0, WT_TOP));
            end else begin
                w = knap_pkg::WT_W'($urandom_range(0, wmax));
            end
            case ($urandom_range(0, 7))
                0:       v = '0;
                1:       v = '1;
                2, 3:    v = knap_pkg::VAL_W'($urandom_range(0, 3));
                default: v = knap_pkg::VAL_W'($urandom);
            endcase
            send_item(w, v, k == n - 1);
        end
    endtask

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int cap;
        int n;
        int r;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // capacity left at its reset value
        send_item(10'd1023, 16'hFFFF, 1'b0);
        send_item(10'd0, 16'h0000, 1'b0);
        send_item(10'd0, 16'hFFFF, 1'b0);
        send_item(10'd1, 16'd1, 1'b0);
        send_item(10'd511, 16'd40000, 1'b0);
        send_item(10'd512, 16'd40001, 1'b1);
        settle();

        load_capacity(0);
        send_item(10'd0, 16'd9, 1'b0);
        send_item(10'd3, 16'd7, 1'b1);
        settle();

        load_capacity(1);
        send_item(10'd1, 16'd5, 1'b0);
        send_item(10'd1, 16'd6, 1'b0);
        send_item(10'd0, 16'd3, 1'b0);
        send_item(10'd2, 16'hFFFF, 1'b1);
        settle();

        // equal values: a later item must not displace an earlier one
        load_capacity(10);
        send_item(10'd4, 16'd10, 1'b0);
        send_item(10'd6, 16'd10, 1'b0);
        send_item(10'd4, 16'd10, 1'b0);
        send_item(10'd6, 16'd10, 1'b0);
        send_item(10'd10, 16'd20, 1'b1);
        send_item(10'd10, 16'd0, 1'b1);
        settle();

        load_capacity(MAX_CAPACITY);
        send_item(10'd1023, 16'd1, 1'b0);
        send_item(10'd1000, 16'd2, 1'b1);
        settle();

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 11);
            if (r == 0) begin
                cap = 0;
            end else if (r == 1) begin
                cap = 1;
            end else if (r <= 3 && big_items < BIG_BUDGET) begin
                cap = (r == 2) ? MAX_CAPACITY : $urandom_range(100, MAX_CAPACITY - 1);
            end else begin
                cap = $urandom_range(2, 90);
            end
            load_capacity(cap);
            repeat ($urandom_range(1, 3)) begin
                r = $urandom_range(0, 9);
                if (cap > 90) begin
                    n = $urandom_range(1, 6);
                    big_items += n;
                end else if (r == 0) begin
                    n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
                end else if (r == 1) begin
                    n = MAX_ITEMS;
                end else begin
                    n = $urandom_range(1, 12);
                end
                run_set(n, cap);
            end
            settle();
        end

        settle();
        if (mismatches == 0 && results_due == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
